[rtl/rglc_pkg.sv]
`timescale 1ns / 1ps
package rglc_pkg;

  localparam int CORDIC_STEPS_DEF      = 24;
  localparam int SUM_FRACTION_BITS_DEF = 8;

  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int LEN_W  = 32;
  localparam int SUM_W  = 48;
  localparam int ANG_W  = 34;   // cordic datapath, Q30 with headroom
  localparam int MUL_W  = 35;   // shared multiplier operand width
  localparam int HH_W   = 61;   // clamped h/2 in Q60
  localparam int RAD_W  = 62;   // square root radicand
  localparam int ROOT_W = 31;
  localparam int SQRT_STEPS = RAD_W / 2;

  localparam logic [MUL_W-1:0]   BAM_PER_UDEG = MUL_W'(200159983);
  localparam logic [MUL_W-1:0]   CIRCUM_Q8    = MUL_W'(64'd10247724440);
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = ANG_W'(32'h26DD3B6A);
  localparam logic [HH_W-1:0]    Q60_ONE      = HH_W'(1) << 60;
  localparam logic [SUM_W-1:0]   SUM_MAX      = '1;

  // binary-angle arctangent of 2^-i, zero past the table end
  function automatic logic [31:0] atan_bam(input logic [5:0] i);
    logic [31:0] v;
    case (i)
      6'd0:  v = 32'h20000000;
      6'd1:  v = 32'h12E4051E;
      6'd2:  v = 32'h09FB385B;
      6'd3:  v = 32'h051111D4;
      6'd4:  v = 32'h028B0D43;
      6'd5:  v = 32'h0145D7E1;
      6'd6:  v = 32'h00A2F61E;
      6'd7:  v = 32'h00517C55;
      6'd8:  v = 32'h0028BE53;
      6'd9:  v = 32'h00145F2F;
      6'd10: v = 32'h000A2F98;
      6'd11: v = 32'h000517CC;
      6'd12: v = 32'h00028BE6;
      6'd13: v = 32'h000145F3;
      6'd14: v = 32'h0000A2FA;
      6'd15: v = 32'h0000517D;
      6'd16: v = 32'h000028BE;
      6'd17: v = 32'h0000145F;
      6'd18: v = 32'h00000A30;
      6'd19: v = 32'h00000518;
      6'd20: v = 32'h0000028C;
      6'd21: v = 32'h00000146;
      6'd22: v = 32'h000000A3;
      6'd23: v = 32'h00000051;
      6'd24: v = 32'h00000029;
      6'd25: v = 32'h00000014;
      6'd26: v = 32'h0000000A;
      6'd27: v = 32'h00000005;
      6'd28: v = 32'h00000003;
      6'd29: v = 32'h00000001;
      6'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[rtl/rglc_stop_if.sv]
`timescale 1ns / 1ps
interface rglc_stop_if import rglc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;
  logic                    last_point;
  logic                    round_trip;

  modport source (output valid, latitude, longitude, last_point, round_trip, input ready);
  modport sink (input valid, latitude, longitude, last_point, round_trip, output ready);
endinterface

[rtl/rglc_length_if.sv]
`timescale 1ns / 1ps
interface rglc_length_if import rglc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] route_length;
  logic             saturated;

  modport source (output valid, route_length, saturated, input ready);
  modport sink (input valid, route_length, saturated, output ready);
endinterface

[rtl/rglc_cordic.sv]
`timescale 1ns / 1ps
module rglc_cordic import rglc_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    vec_mode,
  input  logic signed [ANG_W-1:0] x_init,
  input  logic signed [ANG_W-1:0] y_init,
  input  logic [31:0]             ang,
  output logic                    done,
  output logic signed [ANG_W-1:0] x_out,
  output logic signed [ANG_W-1:0] y_out,
  output logic signed [ANG_W-1:0] z_out
);
  localparam int CW = $clog2(STEPS + 1);

  logic                    busy;
  logic [CW-1:0]           cnt;
  logic                    mode;
  logic                    flip;
  logic signed [ANG_W-1:0] x, y, z;
  logic signed [ANG_W-1:0] xs, ys, at;
  logic [31:0]             ang_q, ang_turned;
  logic                    flip_in;

  // outside +-90 degrees: turn by half a circle, negate at the end
  assign ang_q      = ang + 32'h40000000;
  assign flip_in    = ang_q[31] & ~vec_mode;
  assign ang_turned = flip_in ? ang + 32'h80000000 : ang;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = ANG_W'(atan_bam(6'(cnt)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
        mode <= vec_mode;
        flip <= flip_in;
        x    <= x_init;
        y    <= y_init;
        z    <= vec_mode ? '0 : ANG_W'(signed'(ang_turned));
      end else if (busy) begin
        if (mode) begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end
        end else begin
          if (z >= 0) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
        end
        cnt  <= cnt + 1'b1;
        busy <= (cnt != CW'(STEPS - 1));
        done <= (cnt == CW'(STEPS - 1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign x_out = flip ? -x : x;
  assign y_out = flip ? -y : y;
  assign z_out = z;
endmodule

[rtl/rglc_isqrt.sv]
`timescale 1ns / 1ps
module rglc_isqrt import rglc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);
  localparam int CW = $clog2(SQRT_STEPS + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [RAD_W-1:0]  v;
  logic [32:0]       rem;
  logic [34:0]       rem_sh, trial;

  // two radicand bits per step, restoring
  assign rem_sh = {rem, v[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
        v    <= value;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        v <= v << 2;
        if (rem_sh >= trial) begin
          rem  <= 33'(rem_sh - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[32:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt  <= cnt + 1'b1;
        busy <= (cnt != CW'(SQRT_STEPS - 1));
        done <= (cnt == CW'(SQRT_STEPS - 1));
      end else begin
        done <= 1'b0;
      end
    end
  end
endmodule

[rtl/route_great_circle_length_core.sv]
`timescale 1ns / 1ps
// the first stop of a route goes straight from idle to the result state; every later stop
// runs conversion, four rotations, the products, two roots, atan2 and the leg into the sum
// throughput: one stop at a time, set by five runs of the shared cordic unit and two of the
// square root unit; not ready while a stop is in work
// reset (rst, synchronous): clears the route sum, the previous-stop flag and the output beat
module route_great_circle_length_core import rglc_pkg::*; #(
  parameter int CORDIC_STEPS      = CORDIC_STEPS_DEF,
  parameter int SUM_FRACTION_BITS = SUM_FRACTION_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  rglc_stop_if.sink    stop_in,
  rglc_length_if.source length_out
);
  // leg rounding: angle * circumference scaled down to the sum's fraction
  localparam int LEG_SH = 24 - SUM_FRACTION_BITS;
  localparam logic [63:0] LEG_RND = 64'd1 << (LEG_SH - 1);
  localparam logic [49:0] OUT_RND = (50'd1 << SUM_FRACTION_BITS) >> 1;

  // one-hot sequencer
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CONV = 8'b0000_0010,   // microdegrees to binary angles
    S_ROT  = 8'b0000_0100,   // four sine/cosine runs
    S_MUL  = 8'b0000_1000,   // h/2 from the products
    S_ROOT = 8'b0001_0000,   // two square roots
    S_VEC  = 8'b0010_0000,   // atan2 run
    S_LEG  = 8'b0100_0000,   // angle to metres, into the sum
    S_FIN  = 8'b1000_0000    // result beat, route state update
  } state_t;

  state_t state;
  logic [2:0] step;

  // route state
  logic signed [LAT_W-1:0] prev_lat;
  logic signed [LON_W-1:0] prev_lon;
  logic                    have_prev;
  logic [SUM_W-1:0]        sum;

  // current stop
  logic signed [LAT_W-1:0] cur_lat;
  logic signed [LON_W-1:0] cur_lon;
  logic                    cur_last;
  logic                    cur_round;

  // working registers
  logic [31:0]             bam [4];
  logic signed [ANG_W-1:0] c1, c2, sa, sb;
  logic signed [63:0]      prod, acc;
  logic [HH_W-1:0]         hh;
  logic [ROOT_W-1:0]       vx, vy;
  logic [31:0]             ang;

  // output beat
  logic             out_valid;
  logic [LEN_W-1:0] out_len;
  logic             out_sat;
  logic             fin_fire;

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  // cordic and root unit hookup
  logic                    cor_start, cor_done, cor_vec;
  logic                    cor_start_next, sq_start_next;
  logic [31:0]             cor_ang;
  logic signed [ANG_W-1:0] cor_x0, cor_y0, cor_x, cor_y, cor_z;
  logic                    sq_start, sq_done;
  logic [RAD_W-1:0]        sq_val;
  logic [ROOT_W-1:0]       sq_root;

  logic [63:0]  leg;
  logic [63:0]  sum_add;
  logic [49:0]  total, metres;
  logic [31:0]  ang_hi;

  assign stop_in.ready      = (state == S_IDLE);
  assign length_out.valid        = out_valid;
  assign length_out.route_length = out_len;
  assign length_out.saturated    = out_sat;

  // route closes once the previous beat has gone or is leaving now
  assign fin_fire = (state == S_FIN) && cur_last && (!out_valid || length_out.ready);

  // unit kicks, registered so each run starts only after its operands have settled
  assign cor_start_next = ((state == S_CONV) && (step == 3'd3)) ||
                          ((state == S_ROT) && cor_done && (step != 3'd3)) ||
                          ((state == S_ROOT) && sq_done && (step != 3'd0));
  assign sq_start_next  = ((state == S_MUL) && (step == 3'd4)) ||
                          ((state == S_ROOT) && sq_done && (step == 3'd0));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CONV: begin
        mul_b = BAM_PER_UDEG;
        case (step[1:0])
          2'd0:    mul_a = MUL_W'(prev_lat);
          2'd1:    mul_a = MUL_W'(cur_lat);
          2'd2:    mul_a = MUL_W'(prev_lon);
          default: mul_a = MUL_W'(cur_lon);
        endcase
      end
      S_MUL: begin
        case (step)
          3'd0: begin
            mul_a = MUL_W'(c1);
            mul_b = MUL_W'(c2);
          end
          3'd1, 3'd2: begin
            mul_a = MUL_W'(prod >>> 30);
            mul_b = MUL_W'(sb);
          end
          default: begin
            mul_a = MUL_W'(sa);
            mul_b = MUL_W'(sa);
          end
        endcase
      end
      S_LEG: begin
        mul_b = CIRCUM_Q8;
        mul_a = (step == 3'd0) ? MUL_W'(ang[31:16]) : MUL_W'(ang[15:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // cordic operands per run
  always_comb begin
    cor_vec = (state == S_VEC);
    cor_x0  = cor_vec ? ANG_W'(vx) : CORDIC_GAIN;
    cor_y0  = cor_vec ? ANG_W'(vy) : '0;
    case (step[1:0])
      2'd0:    cor_ang = bam[0];
      2'd1:    cor_ang = bam[1];
      2'd2:    cor_ang = 32'(signed'(bam[1] - bam[0]) >>> 1);
      default: cor_ang = 32'(signed'(bam[3] - bam[2]) >>> 1);
    endcase
  end

  assign sq_val = (step == 3'd0) ? RAD_W'(hh) : RAD_W'(Q60_ONE - hh);

  assign leg     = (64'(acc) + 64'(prod >>> 16) + LEG_RND) >> LEG_SH;
  assign sum_add = 64'(sum) + leg;

  // doubled unless the route closes on itself
  assign total  = cur_round ? 50'(sum) : {1'b0, sum, 1'b0};
  assign metres = (total + OUT_RND) >> SUM_FRACTION_BITS;

  // atan2 angle clamped to a quarter turn, then doubled
  assign ang_hi = (cor_z < 0) ? 32'd0 :
                  (cor_z > ANG_W'(32'h40000000)) ? 32'h80000000 : {cor_z[30:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      have_prev <= 1'b0;
      sum       <= '0;
      prev_lat  <= '0;
      prev_lon  <= '0;
      out_valid <= 1'b0;
      cor_start <= 1'b0;
      sq_start  <= 1'b0;
    end else begin
      cor_start <= cor_start_next;
      sq_start  <= sq_start_next;
      out_valid <= fin_fire | (out_valid & ~length_out.ready);
      case (state)
        S_IDLE: begin
          if (stop_in.valid) begin
            cur_lat   <= stop_in.latitude;
            cur_lon   <= stop_in.longitude;
            cur_last  <= stop_in.last_point;
            cur_round <= stop_in.round_trip;
            step      <= '0;
            state     <= have_prev ? S_CONV : S_FIN;
          end
        end
        S_CONV: begin
          bam[step[1:0]] <= mul_p[55:24];
          if (step == 3'd3) begin
            step  <= '0;
            state <= S_ROT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_ROT: begin
          if (cor_done) begin
            case (step[1:0])
              2'd0:    c1 <= cor_x;
              2'd1:    c2 <= cor_x;
              2'd2:    sa <= cor_y;
              default: sb <= cor_y;
            endcase
            if (step == 3'd3) begin
              step  <= '0;
              state <= S_MUL;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        S_MUL: begin
          prod <= mul_p[63:0];
          if (step == 3'd3) begin
            acc <= prod;
          end
          if (step == 3'd4) begin
            // clamp h/2 to [0, 1] in Q60
            if ((prod + acc) < 0) begin
              hh <= '0;
            end else if ((prod + acc) > 64'(Q60_ONE)) begin
              hh <= Q60_ONE;
            end else begin
              hh <= HH_W'(prod + acc);
            end
            step  <= '0;
            state <= S_ROOT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            if (step == 3'd0) begin
              vy   <= sq_root;
              step <= 3'd1;
            end else begin
              vx    <= sq_root;
              step  <= '0;
              state <= S_VEC;
            end
          end
        end
        S_VEC: begin
          if (cor_done) begin
            ang   <= ang_hi;
            step  <= '0;
            state <= S_LEG;
          end
        end
        S_LEG: begin
          prod <= mul_p[63:0];
          if (step == 3'd1) begin
            acc <= prod;
          end
          if (step == 3'd2) begin
            sum   <= (sum_add > 64'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
            step  <= '0;
            state <= S_FIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_FIN: begin
          if (!cur_last) begin
            prev_lat  <= cur_lat;
            prev_lon  <= cur_lon;
            have_prev <= 1'b1;
            state     <= S_IDLE;
          end else if (!out_valid || length_out.ready) begin
            // route closes: one result beat, route sum and previous-stop flag cleared
            if (|metres[49:LEN_W]) begin
              out_len <= '1;
              out_sat <= 1'b1;
            end else begin
              out_len <= metres[LEN_W-1:0];
              out_sat <= 1'b0;
            end
            prev_lat  <= cur_lat;
            prev_lon  <= cur_lon;
            have_prev <= 1'b0;
            sum       <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rglc_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (cor_start),
    .vec_mode (cor_vec),
    .x_init   (cor_x0),
    .y_init   (cor_y0),
    .ang      (cor_ang),
    .done     (cor_done),
    .x_out    (cor_x),
    .y_out    (cor_y),
    .z_out    (cor_z)
  );

  rglc_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );
endmodule

[rtl/rglc_checker.sv]
`timescale 1ns / 1ps
module rglc_checker import rglc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [LEN_W-1:0] route_length,
  input logic             saturated
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(route_length) && $stable(saturated))
    else $error("result payload changed while stalled");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> route_length == '1)
    else $error("saturated beat without full-scale length");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("stop taken while previous stop in work");
endmodule

bind route_great_circle_length_core rglc_checker u_rglc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (stop_in.valid),
  .in_ready     (stop_in.ready),
  .out_valid    (length_out.valid),
  .out_ready    (length_out.ready),
  .route_length (length_out.route_length),
  .saturated    (length_out.saturated)
);
